### hdl/pprb_pkg.sv
package pprb_pkg;

  localparam int Ports    = 8;
  localparam int BufBytes = 512;

  localparam int PortW    = $clog2(Ports);
  localparam int BufW     = $clog2(2 * Ports);
  localparam int LenW     = $clog2(BufBytes + 1);
  localparam int WordsBuf = BufBytes / 8;
  localparam int WordW    = $clog2(WordsBuf);
  localparam int MemAddrW = BufW + WordW;
  localparam int MemWords = 2 * Ports * WordsBuf;

  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic {
    FuncFrame = 1'b0,
    FuncRead  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    StAccepted   = 3'd0,
    StPortUnused = 3'd1,
    StBufFull    = 3'd2,
    StTruncated  = 3'd3,
    StDelivered  = 3'd4,
    StNoneReady  = 3'd5,
    StTooLong    = 3'd6,
    StReadUnused = 3'd7
  } status_e;

  typedef enum logic {
    RegPortEnable = 1'b0
  } reg_idx_e;

endpackage

### hdl/pprb_if.sv
interface pprb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [pprb_pkg::PortW-1:0]  port;
  logic [7:0]                  data_byte;
  logic                        has_byte;
  logic                        frame_end;
  logic                        more_follows;
  logic [pprb_pkg::LenW-1:0]   max_len;

  modport source (
    output valid, func, port, data_byte, has_byte, frame_end, more_follows, max_len,
    input  ready
  );
  modport sink (
    input  valid, func, port, data_byte, has_byte, frame_end, more_follows, max_len,
    output ready
  );
endinterface

interface pprb_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [pprb_pkg::LenW-1:0]   length;
  logic [63:0]                 data_word;
  logic                        last;

  modport source (
    output valid, status, length, data_word, last,
    input  ready
  );
  modport sink (
    input  valid, status, length, data_word, last,
    output ready
  );
endinterface

### hdl/per_port_ping_pong_reassembly.sv
// Per-port packet reassembly, two alternating buffers (A/B) per port.
// in_i takes items: frame payload bytes (func 0) or read requests (func 1).
// out_o returns results; every item gives one result, a delivered packet
// gives one result per 64-bit word (one if empty), last marks the final one.
// Frame items and single-result requests: result valid the cycle after the
// item is taken, one item per cycle while out_o is drained.
// Delivery: each word is read from the single-port packet memory (SRdAddr),
// then the registered data moves into the output register (SRdData, waits
// on a stalled out_o); in_i is held off until the final word is there.
// Port claiming sits in an APB register (port_enable_mask at offset 0).
// Reset clears selectors, fill counts, full flags, trunc flag and the mask;
// the packet memory is not cleared, as only written bytes are ever read.
// A stalled out_o holds its result and in_i.ready drops until it is taken.
module per_port_ping_pong_reassembly (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pprb_in_if.sink                       in_i,
  pprb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pprb_pkg::ApbAddrW-1:0] paddr,
  input  logic [pprb_pkg::ApbDataW-1:0] pwdata,
  output logic [pprb_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    SIdle   = 3'b001,
    SRdAddr = 3'b010,
    SRdData = 3'b100
  } state_e;

  localparam int LenW  = pprb_pkg::LenW;
  localparam int WordW = pprb_pkg::WordW;
  localparam int BufW  = pprb_pkg::BufW;

  state_e state_q, state_d;

  logic [pprb_pkg::Ports-1:0] mask_q;
  logic [LenW-1:0]            fill_q [2*pprb_pkg::Ports];
  logic [2*pprb_pkg::Ports-1:0] full_q;
  logic [pprb_pkg::Ports-1:0] wsel_q;
  logic [pprb_pkg::Ports-1:0] rsel_q;
  logic                       trunc_q, trunc_d;

  logic [63:0]                pkt_mem_q [pprb_pkg::MemWords];
  logic [63:0]                rdata_q;

  logic [BufW-1:0]            rd_buf_q;
  logic [LenW-1:0]            rd_len_q;
  logic [WordW-1:0]           rd_word_q, rd_last_q;

  logic                       out_valid_q;
  pprb_pkg::status_e          out_status_q;
  logic [LenW-1:0]            out_len_q;
  logic [63:0]                out_data_q;
  logic                       out_last_q;

  logic                       in_fire, out_free, claimed;
  logic [BufW-1:0]            wbuf, rbuf, clr_buf;
  logic [LenW-1:0]            wfill, rlen, rem, rlen_m1;
  pprb_pkg::status_e          st;
  logic [LenW-1:0]            st_len;
  logic                       wr_byte, trunc_n, mark_full, go_read, clr_now;
  logic                       mem_re, rd_done, rd_load, clr_en, cfg_wr;
  logic [63:0]                rd_word_masked;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pprb_pkg::RegPortEnable);
  assign prdata = (paddr[2] == pprb_pkg::RegPortEnable)
                  ? pprb_pkg::ApbDataW'(mask_q) : '0;

  // ---------------- item decode ----------------
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == SIdle) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign claimed = mask_q[in_i.port];
  assign wbuf    = {in_i.port, wsel_q[in_i.port]};
  assign rbuf    = {in_i.port, rsel_q[in_i.port]};
  assign wfill   = fill_q[wbuf];
  assign rlen    = fill_q[rbuf];
  assign rlen_m1 = rlen - LenW'(1);

  always_comb begin
    st        = pprb_pkg::StAccepted;
    st_len    = '0;
    wr_byte   = 1'b0;
    trunc_n   = trunc_q;
    mark_full = 1'b0;
    go_read   = 1'b0;
    clr_now   = 1'b0;
    if (in_i.func == pprb_pkg::FuncFrame) begin
      if (!claimed) begin
        st = pprb_pkg::StPortUnused;
      end else if (full_q[wbuf]) begin
        st = pprb_pkg::StBufFull;
      end else begin
        if (in_i.has_byte) begin
          if (wfill < LenW'(pprb_pkg::BufBytes)) begin
            wr_byte = 1'b1;
          end else begin
            trunc_n = 1'b1;
          end
        end
        st        = trunc_n ? pprb_pkg::StTruncated : pprb_pkg::StAccepted;
        mark_full = in_i.frame_end && !in_i.more_follows;
      end
    end else begin
      if (!claimed) begin
        st = pprb_pkg::StReadUnused;
      end else if (!full_q[rbuf]) begin
        st = pprb_pkg::StNoneReady;
      end else if (rlen > in_i.max_len) begin
        st     = pprb_pkg::StTooLong;
        st_len = rlen;
      end else if (rlen == '0) begin
        st      = pprb_pkg::StDelivered;
        clr_now = 1'b1;
      end else begin
        go_read = 1'b1;
      end
    end
    trunc_d = in_i.frame_end ? 1'b0 : trunc_n;
  end

  // ---------------- delivery sequencer ----------------
  assign mem_re  = (state_q == SRdAddr);
  assign rd_load = (state_q == SRdData) && out_free;
  assign rd_done = rd_load && (rd_word_q == rd_last_q);
  assign clr_en  = rd_done || (in_fire && clr_now);
  assign clr_buf = rd_done ? rd_buf_q : rbuf;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (in_fire && go_read) state_d = SRdAddr;
      SRdAddr: state_d = SRdData;
      SRdData: begin
        if (rd_done) begin
          state_d = SIdle;
        end else if (rd_load) begin
          state_d = SRdAddr;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // bytes past the packet end read as zero
  assign rem = rd_len_q - LenW'({rd_word_q, 3'b000});
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rd_word_masked[8*i +: 8] = (rem > LenW'(i)) ? rdata_q[8*i +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && wr_byte) begin
      pkt_mem_q[{wbuf, wfill[WordW+2:3]}][{wfill[2:0], 3'b000} +: 8] <= in_i.data_byte;
    end
    if (mem_re) begin
      rdata_q <= pkt_mem_q[{rd_buf_q, rd_word_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && go_read) begin
      rd_buf_q  <= rbuf;
      rd_len_q  <= rlen;
      rd_word_q <= '0;
      rd_last_q <= rlen_m1[WordW+2:3];
    end else if (rd_load) begin
      rd_word_q <= rd_word_q + WordW'(1);
    end
  end

  // ---------------- state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mask_q  <= '0;
      full_q  <= '0;
      wsel_q  <= '0;
      rsel_q  <= '0;
      trunc_q <= 1'b0;
      for (int b = 0; b < 2*pprb_pkg::Ports; b++) begin
        fill_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        mask_q <= pwdata[pprb_pkg::Ports-1:0];
      end
      if (in_fire && (in_i.func == pprb_pkg::FuncFrame)) begin
        trunc_q <= trunc_d;
        if (wr_byte) begin
          fill_q[wbuf] <= wfill + LenW'(1);
        end
        if (mark_full) begin
          full_q[wbuf]           <= 1'b1;
          wsel_q[in_i.port]      <= ~wsel_q[in_i.port];
        end
      end
      if (clr_en) begin
        fill_q[clr_buf]            <= '0;
        full_q[clr_buf]            <= 1'b0;
        rsel_q[clr_buf[BufW-1:1]]  <= ~rsel_q[clr_buf[BufW-1:1]];
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((in_fire && !go_read) || rd_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_load) begin
      out_status_q <= pprb_pkg::StDelivered;
      out_len_q    <= rd_len_q;
      out_data_q   <= rd_word_masked;
      out_last_q   <= rd_done;
    end else if (in_fire && !go_read) begin
      out_status_q <= st;
      out_len_q    <= st_len;
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.length    = out_len_q;
  assign out_o.data_word = out_data_q;
  assign out_o.last      = out_last_q;

  // ---------------- assertions ----------------
  a_rd_buf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> full_q[rd_buf_q])
    else $error("delivering from a buffer that is not full");

  a_rd_word_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> (rd_word_q <= rd_last_q))
    else $error("word counter ran past the packet");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wfill <= LenW'(pprb_pkg::BufBytes)) && (rlen <= LenW'(pprb_pkg::BufBytes)))
    else $error("fill count beyond buffer size");

  a_rd_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_done |=> (!full_q[$past(rd_buf_q)] && (fill_q[$past(rd_buf_q)] == '0)))
    else $error("buffer not released after delivery");

endmodule

### bench/tb_per_port_ping_pong_reassembly.sv
module tb_per_port_ping_pong_reassembly;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 500000;

  typedef struct packed {
    pprb_pkg::func_e                func;
    logic [pprb_pkg::PortW-1:0]     port;
    logic [7:0]                     data;
    logic                           has;
    logic                           fend;
    logic                           more;
    logic [pprb_pkg::LenW-1:0]      max_len;
  } item_t;

  typedef struct packed {
    pprb_pkg::status_e              status;
    logic [pprb_pkg::LenW-1:0]      length;
    logic [63:0]                    word;
    logic                           last;
  } result_t;

  // Tracks both buffers of every port and queues the results each item gives.
  class port_buffer_model;
    logic [7:0]  store [2*pprb_pkg::Ports][pprb_pkg::BufBytes];
    int unsigned fill [2*pprb_pkg::Ports];
    bit          full [2*pprb_pkg::Ports];
    bit          wsel [pprb_pkg::Ports];
    bit          rsel [pprb_pkg::Ports];
    bit          trunc;
    logic [7:0]  mask;
    result_t     due_results [$];
    int          mismatches;

    function void set_mask(logic [7:0] value);
      mask = value;
    endfunction

    function void queue_result(pprb_pkg::status_e st, int unsigned len, logic [63:0] w,
                               bit lst);
      result_t r;
      r.status = st;
      r.length = pprb_pkg::LenW'(len);
      r.word   = w;
      r.last   = lst;
      due_results.push_back(r);
    endfunction

    function void accept_item(item_t it);
      int                b;
      int unsigned       len;
      int unsigned       words;
      logic [63:0]       w;
      pprb_pkg::status_e st;
      if (it.func == pprb_pkg::FuncFrame) begin
        if (!mask[it.port]) begin
          st = pprb_pkg::StPortUnused;
        end else begin
          b = 2 * int'(it.port) + int'(wsel[it.port]);
          if (full[b]) begin
            st = pprb_pkg::StBufFull;
          end else begin
            if (it.has) begin
              if (fill[b] < pprb_pkg::BufBytes) begin
                store[b][fill[b]] = it.data;
                fill[b]++;
              end else begin
                trunc = 1'b1;
              end
            end
            st = trunc ? pprb_pkg::StTruncated : pprb_pkg::StAccepted;
            if (it.fend && !it.more) begin
              full[b] = 1'b1;
              wsel[it.port] = ~wsel[it.port];
            end
          end
        end
        if (it.fend) trunc = 1'b0;
        queue_result(st, 0, '0, 1'b1);
      end else if (!mask[it.port]) begin
        queue_result(pprb_pkg::StReadUnused, 0, '0, 1'b1);
      end else begin
        b = 2 * int'(it.port) + int'(rsel[it.port]);
        len = fill[b];
        if (!full[b]) begin
          queue_result(pprb_pkg::StNoneReady, 0, '0, 1'b1);
        end else if (len > it.max_len) begin
          queue_result(pprb_pkg::StTooLong, len, '0, 1'b1);
        end else begin
          words = (len + 7) / 8;
          if (words == 0) queue_result(pprb_pkg::StDelivered, 0, '0, 1'b1);
          for (int k = 0; k < words; k++) begin
            w = '0;
            for (int i = 0; i < 8; i++)
              if (k * 8 + i < len) w[8*i +: 8] = store[b][k*8+i];
            queue_result(pprb_pkg::StDelivered, len, w, k == words - 1);
          end
          fill[b] = 0;
          full[b] = 1'b0;
          rsel[it.port] = ~rsel[it.port];
        end
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d length %0d word %h last %b",
                 $time, got.status, got.length, got.word, got.last);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected status %0d length %0d word %h last %b",
                 $time, want.status, want.length, want.word, want.last);
        $display("%0t:                  actual status %0d length %0d word %h last %b",
                 $time, got.status, got.length, got.word, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pprb_pkg::ApbAddrW-1:0] paddr;
  logic [pprb_pkg::ApbDataW-1:0] pwdata;
  logic [pprb_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  pprb_in_if  in_if ();
  pprb_out_if out_if ();

  per_port_ping_pong_reassembly dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  port_buffer_model model;
  int               idle_pct = 11;
  int               sent;
  int               cycles;
  logic [7:0]       port_mask;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) out_if.ready <= ($urandom_range(0, 99) >= idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      model.check_result({pprb_pkg::status_e'(out_if.status), out_if.length,
                          out_if.data_word, out_if.last});
  end

  task automatic reg_write(input pprb_pkg::reg_idx_e idx,
                           input logic [pprb_pkg::ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == pprb_pkg::RegPortEnable) begin
      port_mask = value[7:0];
      model.set_mask(value[7:0]);
    end
  endtask

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= it.func;
    in_if.port         <= it.port;
    in_if.data_byte    <= it.data;
    in_if.has_byte     <= it.has;
    in_if.frame_end    <= it.fend;
    in_if.more_follows <= it.more;
    in_if.max_len      <= it.max_len;
    do @(posedge clk_i); while (!in_if.ready);
    model.accept_item(it);
    sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (model.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_frame(input int p, input logic [7:0] data, input bit has,
                            input bit fend, input bit more);
    item_t it;
    it.func    = pprb_pkg::FuncFrame;
    it.port    = pprb_pkg::PortW'(p);
    it.data    = data;
    it.has     = has;
    it.fend    = fend;
    it.more    = more;
    it.max_len = pprb_pkg::LenW'($urandom_range(0, 512));
    send_item(it);
  endtask

  task automatic send_read(input int p, input int max_len);
    item_t it;
    it.func    = pprb_pkg::FuncRead;
    it.port    = pprb_pkg::PortW'(p);
    it.data    = 8'($urandom);
    it.has     = 1'($urandom);
    it.fend    = 1'($urandom);
    it.more    = 1'($urandom);
    it.max_len = pprb_pkg::LenW'(max_len);
    send_item(it);
  endtask

  function automatic int pick_port();
    int p;
    p = $urandom_range(0, pprb_pkg::Ports - 1);
    if (port_mask != 0 && $urandom_range(0, 4) != 0)
      while (!port_mask[p]) p = $urandom_range(0, pprb_pkg::Ports - 1);
    return p;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 512;
    if (r < 8) return $urandom_range(0, 512);
    return $urandom_range(0, 40);
  endfunction

  // Packet of several frames; only the final frame clears more-follows.
  task automatic send_packet(input int p, input int frames, input int max_bytes);
    int n;
    for (int f = 0; f < frames; f++) begin
      n = $urandom_range(0, max_bytes);
      if (n == 0) send_frame(p, 8'($urandom), 1'b0, 1'b1, f != frames - 1);
      for (int i = 0; i < n; i++)
        send_frame(p, 8'($urandom), 1'b1, i == n - 1,
                   (i == n - 1) ? (f != frames - 1) : 1'($urandom));
    end
  endtask

  task automatic run_traffic(input int count);
    int start;
    int r;
    item_t it;
    start = sent;
    while (sent - start < count) begin
      r = $urandom_range(0, 39);
      if (r < 22) begin
        send_packet(pick_port(), $urandom_range(1, 3),
                    ($urandom_range(0, 9) == 0) ? 80 : 10);
      end else if (r < 34) begin
        send_read(pick_port(), pick_len());
      end else if (r < 39) begin
        it = item_t'({$urandom, $urandom});
        it.max_len = pprb_pkg::LenW'($urandom_range(0, 512));
        send_item(it);
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    model = new();
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.func         <= pprb_pkg::FuncFrame;
    in_if.port         <= '0;
    in_if.data_byte    <= '0;
    in_if.has_byte     <= 1'b0;
    in_if.frame_end    <= 1'b0;
    in_if.more_follows <= 1'b0;
    in_if.max_len      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // port 7 left unclaimed
    reg_write(pprb_pkg::RegPortEnable, 32'h7F);
    send_frame(7, 8'hAA, 1'b1, 1'b1, 1'b0);
    send_read(7, 512);
    send_read(0, 512);
    send_frame(0, 8'h00, 1'b1, 1'b0, 1'b1);
    send_frame(0, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_frame(0, 8'h5A, 1'b1, 1'b1, 1'b0);
    send_frame(0, 8'h00, 1'b0, 1'b1, 1'b0);
    send_frame(0, 8'h11, 1'b1, 1'b0, 1'b0);
    send_frame(0, 8'h22, 1'b0, 1'b0, 1'b1);
    send_read(0, 2);
    send_read(0, 0);
    send_read(0, 3);
    send_read(0, 0);
    send_read(0, 512);
    send_frame(2, 8'h33, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++)
      send_frame(0, 8'(8'h80 + i), 1'b1, i == 8, 1'b0);
    send_read(0, 512);
    wait_drained();

    // overflow of one buffer, then full-size delivery, with no idling
    idle_pct = 0;
    for (int i = 0; i < pprb_pkg::BufBytes + 2; i++)
      send_frame(1, 8'($urandom), 1'b1, (i % 100) == 99, 1'b1);
    send_frame(1, 8'h00, 1'b0, 1'b1, 1'b0);
    send_read(1, pprb_pkg::BufBytes - 1);
    send_read(1, pprb_pkg::BufBytes);
    wait_drained();
    idle_pct = 11;

    reg_write(pprb_pkg::RegPortEnable, 32'hFF);
    run_traffic(70);
    wait_drained();
    reg_write(pprb_pkg::RegPortEnable, 32'h00);
    run_traffic(20);
    wait_drained();
    reg_write(pprb_pkg::RegPortEnable, {24'h0, 8'($urandom)});
    run_traffic(70);
    wait_drained();
    reg_write(pprb_pkg::RegPortEnable, 32'hFF);
    run_traffic(70);
    wait_drained();
    reg_write(pprb_pkg::RegPortEnable, {24'h0, 8'($urandom)});
    run_traffic(70);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (model.mismatches == 0 && model.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pprb_pkg.sv
hdl/pprb_if.sv
hdl/per_port_ping_pong_reassembly.sv
bench/tb_per_port_ping_pong_reassembly.sv
